// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl
// no dependencies; expects a clock named clk and a reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define CHK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define CHK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/capp_pkg.sv =====
// shared types and constants for the checker alpha preview pack unit
// no dependencies
package capp_pkg;

  localparam int CH_W = 16;
  localparam int NUM_CH = 3;
  localparam int BYTE_W = 8;
  localparam logic [BYTE_W-1:0] OPAQUE_ALPHA = 8'hFF;

  typedef logic signed [CH_W-1:0] chan_t;
  typedef logic [CH_W-1:0] coord_t;
  typedef logic [BYTE_W-1:0] byte_t;

endpackage

// ===== hw/rtl/checker_alpha_preview_pack_unit.sv =====
// checker alpha preview pack unit: alpha composite over checkerboard, packed to argb8888
// depends on capp_pkg and assert_macros.svh
//
// usage:
//   input channel: in_valid / in_stall with pixel_x, pixel_y and the four signed
//   channels red_in, green_in, blue_in, alpha_in carrying FRAC_BITS fraction bits.
//   output channel: out_valid / out_stall with argb_pixel (alpha byte always 0xFF).
//   config channel: cfg_valid / cfg_ready with show_alpha; cfg_ready is always high
//   and the bit is written whenever cfg_valid is high. write it only while idle.
// pipeline: four register stages, one each for decode, the channel and gray multiplies,
//   sum and clamp, and byte scaling with rounding; an accepted transaction moves
//   through them in that order and out_valid rises when it reaches the last one.
// throughput: one pixel per cycle while out_stall is low; each stage holds one
//   transaction and moves forward whenever the stage after it is empty or moving.
// reset (rst, synchronous): empties every stage, clears out_valid and the stored show_alpha bit.
// receiver stall: the output register holds its transaction; stages behind it
//   fill up and in_stall rises only once all of them hold data.
`include "assert_macros.svh"

module checker_alpha_preview_pack_unit #(
  parameter int FRAC_BITS = 12
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            show_alpha,
  input  logic            in_valid,
  output logic            in_stall,
  input  capp_pkg::coord_t pixel_x,
  input  capp_pkg::coord_t pixel_y,
  input  capp_pkg::chan_t red_in,
  input  capp_pkg::chan_t green_in,
  input  capp_pkg::chan_t blue_in,
  input  capp_pkg::chan_t alpha_in,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [31:0]     argb_pixel
);
  import capp_pkg::*;

  localparam int AW = FRAC_BITS + 1;
  localparam int PW1 = CH_W + AW + 1;
  localparam int PW2 = FRAC_BITS + AW;
  localparam int SW = ((CH_W + AW + 1 > PW2 + 1) ? CH_W + AW + 1 : PW2 + 1) + 1;
  localparam int VW = 2 * FRAC_BITS + 1;
  localparam int XW = VW + BYTE_W;
  localparam logic [AW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS-1:0] G04 = FRAC_BITS'((4 * (2 ** FRAC_BITS) + 5) / 10);
  localparam logic [FRAC_BITS-1:0] G06 = FRAC_BITS'((6 * (2 ** FRAC_BITS) + 5) / 10);
  localparam logic [VW-1:0] FULL = {1'b1, {(2 * FRAC_BITS){1'b0}}};
  localparam logic [XW-1:0] HALF = {{(BYTE_W + 1){1'b0}}, 1'b1, {(2 * FRAC_BITS - 1){1'b0}}};

  logic alpha_en;

  logic load1, load2, load3, load4;

  chan_t                      c_in [NUM_CH];
  logic signed [CH_W+AW-1:0]  alpha_ext;
  logic signed [CH_W+AW-1:0]  one_ext;
  logic                       blend;
  logic                       odd_tile;
  logic [AW-1:0]              a_eff;

  logic                       s1_valid;
  chan_t                      s1_c [NUM_CH];
  logic [AW-1:0]              s1_a;
  logic [AW-1:0]              s1_inv;
  logic [FRAC_BITS-1:0]       s1_gray;

  logic                       s2_valid;
  logic signed [PW1-1:0]      s2_p1 [NUM_CH];
  logic [PW2-1:0]             s2_p2;

  logic                       s3_valid;
  logic [VW-1:0]              s3_v [NUM_CH];
  logic signed [SW-1:0]       sum [NUM_CH];
  logic [VW-1:0]              clamped [NUM_CH];

  logic [XW-1:0]              scaled [NUM_CH];
  byte_t                      chan_byte [NUM_CH];

  // config register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_en <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      alpha_en <= show_alpha;
    end
  end

  // stage enables
  assign load4 = !out_valid || !out_stall;
  assign load3 = !s3_valid || load4;
  assign load2 = !s2_valid || load3;
  assign load1 = !s1_valid || load2;
  assign in_stall = !load1;

  // decode
  assign c_in[0] = red_in;
  assign c_in[1] = green_in;
  assign c_in[2] = blue_in;
  assign alpha_ext = {{AW{alpha_in[CH_W-1]}}, alpha_in};
  assign one_ext = {{CH_W{1'b0}}, ONE};
  assign blend = alpha_en && (alpha_ext < one_ext);
  assign odd_tile = pixel_x[3] ^ pixel_y[3];

  always_comb begin
    if (!blend) begin
      a_eff = ONE;
    end else if (alpha_in[CH_W-1]) begin
      a_eff = '0;
    end else begin
      a_eff = alpha_ext[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load1) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      s1_c    <= c_in;
      s1_a    <= a_eff;
      s1_inv  <= ONE - a_eff;
      s1_gray <= odd_tile ? G04 : G06;
    end
  end

  // multiplies
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (load2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load2) begin
      for (int i = 0; i < NUM_CH; i++) begin
        s2_p1[i] <= PW1'(s1_c[i]) * PW1'($signed({1'b0, s1_a}));
      end
      s2_p2 <= {{AW{1'b0}}, s1_gray} * {{FRAC_BITS{1'b0}}, s1_inv};
    end
  end

  // sum and clamp
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      sum[i] = {{(SW - PW1){s2_p1[i][PW1-1]}}, s2_p1[i]}
               + $signed({{(SW - PW2){1'b0}}, s2_p2});
      if (sum[i][SW-1]) begin
        clamped[i] = '0;
      end else if (sum[i] > $signed({{(SW - VW){1'b0}}, FULL})) begin
        clamped[i] = FULL;
      end else begin
        clamped[i] = sum[i][VW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (load3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load3) begin
      s3_v <= clamped;
    end
  end

  // scale by 255 with round half up
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      scaled[i] = ({s3_v[i], {BYTE_W{1'b0}}} - {{BYTE_W{1'b0}}, s3_v[i]}) + HALF;
      chan_byte[i] = scaled[i][2*FRAC_BITS+BYTE_W-1:2*FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load4) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load4) begin
      argb_pixel <= {OPAQUE_ALPHA, chan_byte[0], chan_byte[1], chan_byte[2]};
    end
  end

  `CHK_ASSERT(a_stall_only_when_full,
              in_stall |-> (out_valid && out_stall && s1_valid && s2_valid && s3_valid),
              "input stalled while pipeline has room")
  `CHK_ASSERT(a_clamp_range,
              s3_valid |-> (s3_v[0] <= FULL && s3_v[1] <= FULL && s3_v[2] <= FULL),
              "clamped channel above full scale")
  `CHK_ASSERT(a_opaque_out,
              out_valid |-> (argb_pixel[31:24] == OPAQUE_ALPHA),
              "output alpha byte not opaque")
  `CHK_ASSERT_ALWAYS(a_reset_empty,
                     rst |=> (!out_valid && !in_stall && !s1_valid),
                     "pipeline not empty after reset")

endmodule

// ===== sim/capp_pack_checker.sv =====
// checker for the checker alpha preview pack unit: predicts each argb pixel and compares
// watches the config, input and output channels; depends on capp_pkg
module capp_pack_checker #(
  parameter int FRAC_BITS = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic             show_alpha,
  input  logic             in_valid,
  input  logic             in_stall,
  input  capp_pkg::coord_t pixel_x,
  input  capp_pkg::coord_t pixel_y,
  input  capp_pkg::chan_t  red_in,
  input  capp_pkg::chan_t  green_in,
  input  capp_pkg::chan_t  blue_in,
  input  capp_pkg::chan_t  alpha_in,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [31:0]      argb_pixel,
  output int               fail_count,
  output int               pending_count
);
  import capp_pkg::*;

  localparam int MAX_REPORTS = 10;
  localparam longint ONE = longint'(1) << FRAC_BITS;
  localparam longint FULL = ONE * ONE;
  localparam longint GRAY_DARK = (4 * ONE + 5) / 10;
  localparam longint GRAY_LIGHT = (6 * ONE + 5) / 10;

  logic        blend_on;
  logic [31:0] argb_expected_q[$];
  int          pixel_index;

  function automatic byte_t channel_to_byte(input longint level);
    longint v;
    v = level;
    if (v < 0) v = 0;
    if (v > FULL) v = FULL;
    return byte_t'((v * 255 + FULL / 2) >> (2 * FRAC_BITS));
  endfunction

  function automatic logic [31:0] composite_argb(input logic blend, input coord_t x,
                                                  input coord_t y, input chan_t r,
                                                  input chan_t g, input chan_t b,
                                                  input chan_t a);
    longint c[3];
    longint level[3];
    longint alpha;
    longint gray;
    c[0] = longint'(r);
    c[1] = longint'(g);
    c[2] = longint'(b);
    alpha = longint'(a);
    if (blend && alpha < ONE) begin
      gray = (x[3] ^ y[3]) ? GRAY_DARK : GRAY_LIGHT;
      if (alpha < 0) alpha = 0;
      for (int i = 0; i < 3; i++) level[i] = c[i] * alpha + gray * (ONE - alpha);
    end else begin
      for (int i = 0; i < 3; i++) level[i] = c[i] * ONE;
    end
    return {OPAQUE_ALPHA, channel_to_byte(level[0]), channel_to_byte(level[1]),
            channel_to_byte(level[2])};
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      blend_on = 1'b0;
    end else begin
      // compare before queuing so a transaction never meets its own prediction
      if (out_valid && !out_stall) begin
        if (argb_expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected output transaction: argb %08h", argb_pixel);
        end else begin
          logic [31:0] want;
          want = argb_expected_q.pop_front();
          if (argb_pixel !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("pixel %0d: argb_pixel expected %08h, got %08h",
                       pixel_index, want, argb_pixel);
          end
          pixel_index++;
        end
      end
      if (in_valid && !in_stall)
        argb_expected_q.push_back(composite_argb(blend_on, pixel_x, pixel_y, red_in,
                                                 green_in, blue_in, alpha_in));
      if (cfg_valid && cfg_ready) blend_on = show_alpha;
    end
    pending_count = argb_expected_q.size();
  end

endmodule

// ===== sim/checker_alpha_preview_pack_unit_tb.sv =====
// testbench top for the checker alpha preview pack unit: clock, reset, stimulus and verdict
// depends on capp_pkg, checker_alpha_preview_pack_unit and capp_pack_checker
module checker_alpha_preview_pack_unit_tb;
  import capp_pkg::*;

  localparam int FRAC_BITS = 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        show_alpha = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  coord_t      pixel_x = '0;
  coord_t      pixel_y = '0;
  chan_t       red_in = '0;
  chan_t       green_in = '0;
  chan_t       blue_in = '0;
  chan_t       alpha_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] argb_pixel;

  int fail_count;
  int pending_count;
  int cycle_count;
  bit burst_mode = 1'b0;

  checker_alpha_preview_pack_unit #(.FRAC_BITS(FRAC_BITS)) DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .show_alpha(show_alpha),
    .in_valid(in_valid), .in_stall(in_stall),
    .pixel_x(pixel_x), .pixel_y(pixel_y),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in), .alpha_in(alpha_in),
    .out_valid(out_valid), .out_stall(out_stall), .argb_pixel(argb_pixel)
  );

  capp_pack_checker #(.FRAC_BITS(FRAC_BITS)) pack_check (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .show_alpha(show_alpha),
    .in_valid(in_valid), .in_stall(in_stall),
    .pixel_x(pixel_x), .pixel_y(pixel_y),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in), .alpha_in(alpha_in),
    .out_valid(out_valid), .out_stall(out_stall), .argb_pixel(argb_pixel),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic chan_t pick_color();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return chan_t'(int'($urandom_range(0, 4608)) - 256);
    if (r < 75) return chan_t'($urandom);
    if (r < 85) begin
      case ($urandom_range(0, 6))
        0: return chan_t'(0);
        1: return chan_t'(4096);
        2: return chan_t'(4095);
        3: return chan_t'(1);
        4: return chan_t'(-1);
        5: return chan_t'(-32768);
        default: return chan_t'(32767);
      endcase
    end
    return chan_t'($urandom_range(4096, 32767));
  endfunction

  function automatic chan_t pick_alpha();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return chan_t'($urandom_range(0, 4095));
    if (r < 55) begin
      case ($urandom_range(0, 3))
        0: return chan_t'(0);
        1: return chan_t'(1);
        2: return chan_t'(4095);
        default: return chan_t'(4096);
      endcase
    end
    if (r < 70) return chan_t'(-int'($urandom_range(1, 32768)));
    if (r < 85) return chan_t'($urandom_range(4096, 32767));
    return chan_t'($urandom);
  endfunction

  task automatic send_pixel(input coord_t x, input coord_t y, input chan_t r,
                            input chan_t g, input chan_t b, input chan_t a);
    int gap;
    gap = burst_mode ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixel_x <= x;
    pixel_y <= y;
    red_in <= r;
    green_in <= g;
    blue_in <= b;
    alpha_in <= a;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // only while the pipeline is empty
  task automatic write_show_alpha(input logic enable);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    show_alpha <= enable;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_pixels(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      send_pixel(coord_t'($urandom), coord_t'($urandom), pick_color(), pick_color(),
                 pick_color(), pick_alpha());
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    int run;
    int hold;
    @(negedge clk);
    forever begin
      run = ($urandom_range(0, 99) < 10) ? $urandom_range(50, 150) : $urandom_range(1, 8);
      hold = pick_gap();
      if (hold == 0) hold = 1;
      out_stall <= 1'b0;
      repeat (run) @(negedge clk);
      out_stall <= 1'b1;
      repeat (hold) @(negedge clk);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("checker_alpha_preview_pack_unit_tb: FAIL");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // compositing off after reset: colors pass straight through
    send_pixel(16'd0, 16'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_pixel(16'hFFFF, 16'hFFFF, 16'sd32767, -16'sd32768, 16'sd4096, -16'sd32768);
    send_pixel(16'd8, 16'd0, 16'sd4096, 16'sd4095, 16'sd1, 16'sd4095);
    send_pixel(16'd0, 16'd8, -16'sd1, 16'sd2048, 16'sd2056, 16'sd32767);
    send_pixel(16'h5555, 16'hAAAA, 16'sd16, 16'sd8, 16'sd2040, 16'sd4096);

    write_show_alpha(1'b1);
    // checker tiles, zero and negative alpha, alpha at and above one
    send_pixel(16'd0, 16'd0, 16'sd4096, 16'sd0, 16'sd2048, 16'sd0);
    send_pixel(16'd8, 16'd0, 16'sd4096, 16'sd0, 16'sd2048, 16'sd0);
    send_pixel(16'd0, 16'd8, 16'sd4096, 16'sd0, 16'sd2048, -16'sd1);
    send_pixel(16'd8, 16'd8, 16'sd4096, 16'sd0, 16'sd2048, -16'sd32768);
    send_pixel(16'd0, 16'd0, 16'sd32767, -16'sd32768, 16'sd0, 16'sd4095);
    send_pixel(16'd8, 16'd0, 16'sd32767, -16'sd32768, 16'sd0, 16'sd4096);
    send_pixel(16'hFFFF, 16'hFFFF, 16'sd0, 16'sd4096, -16'sd1, 16'sd32767);
    send_pixel(16'hFFF7, 16'h0008, 16'sd1000, 16'sd3000, 16'sd4096, 16'sd2048);
    send_pixel(16'd3, 16'd5, -16'sd32768, 16'sd32767, 16'sd32767, 16'sd1);
    send_pixel(16'd12, 16'd4, 16'sd2048, 16'sd2048, 16'sd2048, 16'sd2048);

    send_random_pixels(400);
    write_show_alpha(1'b0);
    send_random_pixels(300);
    write_show_alpha(1'b1);
    send_random_pixels(250);
    write_show_alpha(1'b0);
    write_show_alpha(1'b1);
    send_random_pixels(250);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("checker_alpha_preview_pack_unit_tb: PASS");
    end else begin
      $display("checker_alpha_preview_pack_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
